@@ hdl/lge_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lge_pkg
// Shared grid sizes, command codes, FSM type and the B3/S23 row update.
// ----------------------------------------------------------------------------
package lge_pkg;

    localparam int GRID_WIDTH  = 64;
    localparam int GRID_HEIGHT = 64;

    // row address, column index, and a row counter that can hold GRID_HEIGHT
    localparam int ROW_AW = $clog2(GRID_HEIGHT);
    localparam int COL_AW = $clog2(GRID_WIDTH);
    localparam int CNT_W  = $clog2(GRID_HEIGHT + 1);

    localparam logic [1:0] CMD_TOGGLE = 2'd0;
    localparam logic [1:0] CMD_STEP   = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [3:0] SURVIVE_LO = 4'd2;
    localparam logic [3:0] BIRTH_CNT  = 4'd3;

    typedef logic [GRID_WIDTH-1:0] grid_row_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOGGLE,
        ST_READ,
        ST_STEP,
        ST_FINISH
    } lge_state_t;

    // New value of row r from old rows r-1, r, r+1. Edge columns hold.
    function automatic grid_row_t life_row(grid_row_t up, grid_row_t mid, grid_row_t dn);
        grid_row_t  nr;
        logic [3:0] n;
        nr = mid;
        for (int c = 1; c < GRID_WIDTH - 1; c++)
        begin
            n = 4'(up[c-1]) + 4'(up[c]) + 4'(up[c+1])
              + 4'(mid[c-1]) + 4'(mid[c+1])
              + 4'(dn[c-1]) + 4'(dn[c]) + 4'(dn[c+1]);
            if (mid[c])
            begin
                nr[c] = (n == SURVIVE_LO) || (n == BIRTH_CNT);
            end
            else
            begin
                nr[c] = (n == BIRTH_CNT);
            end
        end
        return nr;
    endfunction

endpackage : lge_pkg
`default_nettype wire

@@ hdl/life_generation_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// life_generation_engine
// Conway life grid (B3/S23) with toggle, read and single-generation step.
// ----------------------------------------------------------------------------
//  channel | signals                          | moves
//  --------+----------------------------------+------------------------------
//  cmd     | cmd_valid cmd_ready command row col | one command request
//  res     | res_valid res_ready cell_value   | one result per request
//
//  Toggle and read go through one registered memory read, one update/select
//  step and one output load before the result is valid.
//  Step reads one row per cycle through the single read port, the row update
//  unit writing row r-1 as row r arrives.
//  Reset clears the row valid flags at once; no clearing pass is needed.
//  cmd_ready is high only while idle; a result stalled on res_ready holds the
//  block in its finish state, but the next request is taken while a result
//  waits in the output register.
// ----------------------------------------------------------------------------
module life_generation_engine
    import lge_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    output logic            cmd_ready,
    input  wire logic [1:0] command,
    input  wire logic [5:0] row,
    input  wire logic [5:0] col,
    output logic            res_valid,
    input  wire logic       res_ready,
    output logic            cell_value
);

    // grid storage: one word per row, read data registered
    grid_row_t cell_rows_reg [GRID_HEIGHT];
    logic [GRID_HEIGHT-1:0] row_valid_reg;   // never-written rows read as dead
    grid_row_t rd_data_reg;
    logic      rd_ok_reg;
    logic      rd_pend_reg, rd_pend_next;

    logic              rd_en;
    logic [ROW_AW-1:0] rd_addr;
    logic              wr_en;
    logic [ROW_AW-1:0] wr_addr;
    grid_row_t         wr_data;
    grid_row_t         rd_eff;

    lge_state_t state_reg, state_next;

    // latched request
    logic [ROW_AW-1:0] row_reg, row_next;
    logic [COL_AW-1:0] col_reg, col_next;

    // step sequencer
    logic [CNT_W-1:0] issue_cnt_reg, issue_cnt_next;
    logic [CNT_W-1:0] arr_cnt_reg, arr_cnt_next;
    logic [CNT_W-1:0] arr_m1;
    grid_row_t        w_prev_reg, w_prev_next;
    grid_row_t        w_cur_reg, w_cur_next;

    logic result_reg, result_next;
    logic res_valid_reg, res_valid_next;
    logic cell_value_reg, cell_value_next;

    logic      in_grid;
    grid_row_t toggled;

    assign rd_eff  = rd_ok_reg ? rd_data_reg : '0;
    assign toggled = rd_eff ^ (GRID_WIDTH'(1) << col_reg);
    assign arr_m1  = arr_cnt_reg - CNT_W'(1);
    assign in_grid = (int'(row) < GRID_HEIGHT) && (int'(col) < GRID_WIDTH);

    assign cmd_ready  = (state_reg == ST_IDLE);
    assign res_valid  = res_valid_reg;
    assign cell_value = cell_value_reg;

    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        issue_cnt_next  = issue_cnt_reg;
        arr_cnt_next    = arr_cnt_reg;
        w_prev_next     = w_prev_reg;
        w_cur_next      = w_cur_reg;
        result_next     = result_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        cell_value_next = cell_value_reg;
        rd_en           = 1'b0;
        rd_addr         = row_reg;
        wr_en           = 1'b0;
        wr_addr         = row_reg;
        wr_data         = toggled;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    row_next       = ROW_AW'(row);
                    col_next       = COL_AW'(col);
                    issue_cnt_next = '0;
                    arr_cnt_next   = '0;
                    result_next    = 1'b0;
                    if (command == CMD_STEP)
                    begin
                        state_next = ST_STEP;
                    end
                    else if ((command == CMD_TOGGLE) && in_grid)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = ROW_AW'(row);
                        state_next = ST_TOGGLE;
                    end
                    else if ((command == CMD_READ) && in_grid)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = ROW_AW'(row);
                        state_next = ST_READ;
                    end
                    else
                    begin
                        // outside the grid or unused code: answer 0
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_TOGGLE:
            begin
                wr_en       = 1'b1;
                result_next = toggled[col_reg];
                state_next  = ST_FINISH;
            end
            ST_READ:
            begin
                result_next = rd_eff[col_reg];
                state_next  = ST_FINISH;
            end
            ST_STEP:
            begin
                if (issue_cnt_reg < CNT_W'(GRID_HEIGHT))
                begin
                    rd_en          = 1'b1;
                    rd_addr        = issue_cnt_reg[ROW_AW-1:0];
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                end
                if (rd_pend_reg)
                begin
                    // rows prev/cur are still the old generation here
                    if (arr_cnt_reg >= CNT_W'(2))
                    begin
                        wr_en   = 1'b1;
                        wr_addr = arr_m1[ROW_AW-1:0];
                        wr_data = life_row(w_prev_reg, w_cur_reg, rd_eff);
                    end
                    w_prev_next  = w_cur_reg;
                    w_cur_next   = rd_eff;
                    arr_cnt_next = arr_cnt_reg + CNT_W'(1);
                    if (arr_cnt_reg == CNT_W'(GRID_HEIGHT - 1))
                    begin
                        result_next = 1'b0;
                        state_next  = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next  = 1'b1;
                    cell_value_next = result_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rd_pend_next = rd_en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_valid_reg <= '0;
            rd_ok_reg     <= 1'b0;
            rd_pend_reg   <= 1'b0;
            issue_cnt_reg <= '0;
            arr_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_pend_reg   <= rd_pend_next;
            issue_cnt_reg <= issue_cnt_next;
            arr_cnt_reg   <= arr_cnt_next;
            res_valid_reg <= res_valid_next;
            if (rd_en)
            begin
                rd_ok_reg <= row_valid_reg[rd_addr];
            end
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        col_reg        <= col_next;
        w_prev_reg     <= w_prev_next;
        w_cur_reg      <= w_cur_next;
        result_reg     <= result_next;
        cell_value_reg <= cell_value_next;
    end

    // grid memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cell_rows_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= cell_rows_reg[rd_addr];
        end
    end

    // write never lands on the row being read in the same cycle
    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write hit the same row");

    // a step only rewrites interior rows
    a_step_interior: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && (state_reg == ST_STEP)) |->
            ((wr_addr != '0) && (wr_addr != ROW_AW'(GRID_HEIGHT - 1))))
        else $error("step wrote a boundary row");

    // reads issued always run ahead of rows consumed
    a_issue_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |-> (issue_cnt_reg >= arr_cnt_reg))
        else $error("step consumed a row never read");

    // an accepted request keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready)
        else $error("ready right after accepting a request");

endmodule : life_generation_engine
`default_nettype wire

@@ tb/sv/life_generation_engine_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_generation_engine_test
// Self-checking bench for the B3/S23 life grid: toggle, read and step requests
// are checked against a bit-level grid predictor kept inside the bench.
// ----------------------------------------------------------------------------
module life_generation_engine_test
    import lge_pkg::*;
();

    // The package gives no name for the spare code; it must do nothing and
    // answer with a dead cell.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 850;
    // Cycles with neither channel moving before the run is declared hung.
    // The limit covers a step's full pass over every row; the rest is margin
    // for random stalls on the result side.
    localparam int STALL_LIMIT  = 5000;
    localparam int IDLE_PCT     = 32;
    // Window of cycles in which neither side idles.
    localparam int QUIET_START  = 3000;
    localparam int QUIET_STOP   = 5000;

    typedef struct packed {
        logic [1:0] op;
        logic [5:0] row_addr;
        logic [5:0] col_addr;
    } life_req_t;

    typedef struct {
        life_req_t req;
        logic      value;
    } cell_result_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       cmd_valid  = 1'b0;
    logic       cmd_ready;
    logic [1:0] command    = CMD_TOGGLE;
    logic [5:0] row        = '0;
    logic [5:0] col        = '0;
    logic       res_valid;
    logic       res_ready  = 1'b0;
    logic       cell_value;

    life_generation_engine DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .command    (command),
        .row        (row),
        .col        (col),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .cell_value (cell_value)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Grid predictor: own copy of the cell array, updated as each request is
    // accepted. Row r bit c is column c, same as the block.
    // ------------------------------------------------------------------------
    grid_row_t life_grid [GRID_HEIGHT];

    life_req_t    pending_requests [$];
    cell_result_t expected_cells [$];

    int unsigned total_requests    = 0;
    int unsigned accepted_requests = 0;
    int unsigned error_count       = 0;
    int unsigned cycle_count       = 0;
    int unsigned stall_cycles      = 0;

    // One synchronous generation. Only interior cells change; the outer ring
    // is read as neighbors but never written.
    function automatic void advance_life_grid();
        grid_row_t next_grid [GRID_HEIGHT];
        int        live;
        next_grid = life_grid;
        for (int r = 1; r < GRID_HEIGHT - 1; r++)
        begin
            for (int c = 1; c < GRID_WIDTH - 1; c++)
            begin
                live = 0;
                for (int dr = -1; dr <= 1; dr++)
                begin
                    for (int dc = -1; dc <= 1; dc++)
                    begin
                        if (dr != 0 || dc != 0)
                        begin
                            live += life_grid[r + dr][c + dc];
                        end
                    end
                end
                if (life_grid[r][c])
                begin
                    next_grid[r][c] = (live == SURVIVE_LO) || (live == BIRTH_CNT);
                end
                else
                begin
                    next_grid[r][c] = (live == BIRTH_CNT);
                end
            end
        end
        life_grid = next_grid;
    endfunction

    // Applies one accepted request and returns the cell value it should report.
    function automatic logic apply_life_request(life_req_t req);
        logic on_grid;
        on_grid = (req.row_addr < GRID_HEIGHT) && (req.col_addr < GRID_WIDTH);
        case (req.op)
            CMD_STEP:
            begin
                advance_life_grid();
            end
            CMD_TOGGLE:
            begin
                if (on_grid)
                begin
                    life_grid[req.row_addr][req.col_addr] =
                        ~life_grid[req.row_addr][req.col_addr];
                    return life_grid[req.row_addr][req.col_addr];
                end
            end
            CMD_READ:
            begin
                if (on_grid)
                begin
                    return life_grid[req.row_addr][req.col_addr];
                end
            end
            default:
            begin
            end
        endcase
        return 1'b0;
    endfunction

    task automatic queue_request(logic [1:0] op, logic [5:0] r, logic [5:0] c);
        life_req_t req;
        req.op       = op;
        req.row_addr = r;
        req.col_addr = c;
        pending_requests.push_back(req);
        total_requests++;
    endtask

    task automatic report_fault(string msg);
        if (error_count < 10)
        begin
            $display("%0t: %s", $realtime, msg);
        end
        error_count++;
    endtask

    function automatic bit quiet_stretch();
        return (cycle_count >= QUIET_START) && (cycle_count < QUIET_STOP);
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------------
    // Request driver. The predictor runs at the accepting edge, so the grid
    // copy always matches what the block has been told so far.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        life_req_t    next_req;
        cell_result_t want;
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
            begin
                want.req   = '{op: command, row_addr: row, col_addr: col};
                want.value = apply_life_request(want.req);
                expected_cells.push_back(want);
                accepted_requests <= accepted_requests + 1;
            end
            // Slot is free when nothing is shown or the shown request just went.
            if (!cmd_valid || cmd_ready)
            begin
                if (pending_requests.size() != 0 &&
                    (quiet_stretch() || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    next_req  = pending_requests.pop_front();
                    cmd_valid <= 1'b1;
                    command   <= next_req.op;
                    row       <= next_req.row_addr;
                    col       <= next_req.col_addr;
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: every result is matched against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cell_result_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_cells.size() == 0)
            begin
                report_fault($sformatf("result %0b with no request outstanding",
                                       cell_value));
            end
            else
            begin
                want = expected_cells.pop_front();
                if (cell_value !== want.value)
                begin
                    report_fault($sformatf(
                        "op %0d row %0d col %0d: cell_value exp %0b got %0b",
                        want.req.op, want.req.row_addr, want.req.col_addr,
                        want.value, cell_value));
                end
            end
        end
        res_ready <= rst_n && (quiet_stretch() || $urandom_range(0, 99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // Watchdog: nothing moving on either channel for too long means a hang.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned plan;
        int unsigned r0;
        int unsigned c0;
        int unsigned span;
        int unsigned shape;
        int unsigned cells;
        int unsigned dr;
        int unsigned dc;

        life_grid = '{default: '0};

        // Directed: corners and boundary ring, spare code, boundary feeding a
        // birth just inside, and a blinker through two steps.
        queue_request(CMD_READ,   6'd0,  6'd0);   // untouched cell reads dead
        queue_request(CMD_TOGGLE, 6'd0,  6'd0);
        queue_request(CMD_TOGGLE, 6'd63, 6'd63);
        queue_request(CMD_TOGGLE, 6'd0,  6'd63);
        queue_request(CMD_TOGGLE, 6'd63, 6'd0);
        queue_request(CMD_READ,   6'd63, 6'd63);
        queue_request(CMD_UNUSED, 6'd63, 6'd63);
        queue_request(CMD_STEP,   6'd0,  6'd0);   // corners never update
        queue_request(CMD_READ,   6'd0,  6'd63);
        queue_request(CMD_TOGGLE, 6'd0,  6'd0);   // back to dead
        queue_request(CMD_TOGGLE, 6'd0,  6'd20);
        queue_request(CMD_TOGGLE, 6'd0,  6'd21);
        queue_request(CMD_TOGGLE, 6'd0,  6'd22);
        queue_request(CMD_STEP,   6'd63, 6'd63);
        queue_request(CMD_READ,   6'd1,  6'd21);  // born from the fixed edge
        queue_request(CMD_READ,   6'd0,  6'd21);  // edge holds its value
        queue_request(CMD_TOGGLE, 6'd10, 6'd9);
        queue_request(CMD_TOGGLE, 6'd10, 6'd10);
        queue_request(CMD_TOGGLE, 6'd10, 6'd11);
        queue_request(CMD_STEP,   6'd0,  6'd0);
        queue_request(CMD_READ,   6'd9,  6'd10);
        queue_request(CMD_READ,   6'd10, 6'd9);
        queue_request(CMD_STEP,   6'd0,  6'd0);
        queue_request(CMD_READ,   6'd10, 6'd9);
        queue_request(CMD_UNUSED, 6'd0,  6'd0);

        // Random part: mostly local clusters and known shapes that get
        // stepped and probed, so neighbor counts actually interact; the rest
        // is scattered noise over the whole address space and all codes.
        while (total_requests < 25 + RANDOM_ITEMS)
        begin
            plan = $urandom_range(0, 99);
            r0   = $urandom_range(0, 63);
            c0   = $urandom_range(0, 63);
            if (plan < 55)
            begin
                // Dense cluster; addresses wrap so edges and ring get hit.
                span  = $urandom_range(3, 7);
                cells = $urandom_range(4, 16);
                repeat (cells)
                begin
                    queue_request(CMD_TOGGLE, 6'(r0 + $urandom_range(0, span - 1)),
                                  6'(c0 + $urandom_range(0, span - 1)));
                end
                repeat ($urandom_range(1, 4))
                begin
                    queue_request(CMD_STEP, 6'($urandom), 6'($urandom));
                end
                repeat ($urandom_range(2, 8))
                begin
                    queue_request(CMD_READ, 6'(r0 + $urandom_range(0, span)),
                                  6'(c0 + $urandom_range(0, span)));
                end
            end
            else if (plan < 70)
            begin
                // Blinker, block or glider laid at a random origin.
                shape = $urandom_range(0, 2);
                cells = (shape == 0) ? 3 : (shape == 1) ? 4 : 5;
                for (int k = 0; k < cells; k++)
                begin
                    case (shape)
                        0:
                        begin
                            dr = 1;
                            dc = k;
                        end
                        1:
                        begin
                            dr = k / 2;
                            dc = k % 2;
                        end
                        default:
                        begin
                            dr = (k < 2) ? k : 2;
                            dc = (k == 0) ? 1 : (k == 1) ? 2 : k - 2;
                        end
                    endcase
                    queue_request(CMD_TOGGLE, 6'(r0 + dr), 6'(c0 + dc));
                end
                repeat ($urandom_range(1, 4))
                begin
                    queue_request(CMD_STEP, 6'($urandom), 6'($urandom));
                    repeat ($urandom_range(1, 4))
                    begin
                        queue_request(CMD_READ, 6'(r0 + $urandom_range(0, 3)),
                                      6'(c0 + $urandom_range(0, 3)));
                    end
                end
            end
            else if (plan < 85)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    queue_request(2'($urandom_range(0, 3)), 6'($urandom), 6'($urandom));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    queue_request(CMD_READ, 6'($urandom), 6'($urandom));
                end
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_requests < total_requests || expected_cells.size() != 0)
        begin
            @(posedge clk);
        end
        // Let any stray result surface before judging.
        repeat (GRID_HEIGHT + 8) @(posedge clk);

        if (error_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
